@@ rtl/block_buffer_cache_lru_assert.svh @@
// Assertion macros used by the buffer cache top level.
`ifndef BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_LRU_ASSERT_SVH

// Implication within the same cycle, quiet while reset is applied.
`define BBC_ASSERT_NOW(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |-> (cons)) \
    else $error("bbc assertion failed");

// Implication checked in the following cycle, quiet while reset is applied.
`define BBC_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rst_s)) (ante) |=> (cons)) \
    else $error("bbc assertion failed");

`endif

@@ rtl/bbc_pkg.sv @@
// Types and constants of the block buffer cache.
`default_nettype none
package bbc_pkg;

  localparam logic [2:0] CMD_GET         = 3'd0;
  localparam logic [2:0] CMD_RELEASE     = 3'd1;
  localparam logic [2:0] CMD_MARK_VALID  = 3'd2;
  localparam logic [2:0] CMD_MARK_DIRTY  = 3'd3;
  localparam logic [2:0] CMD_CLEAR_DIRTY = 3'd4;

  localparam int SLOT_W = 5;

  typedef enum logic [2:0] {
    RES_HIT     = 3'd0,
    RES_MISS    = 3'd1,
    RES_BUSY    = 3'd2,
    RES_NONE    = 3'd3,
    RES_NOTBUSY = 3'd4,
    RES_DONE    = 3'd5
  } bbc_status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_FINISH
  } bbc_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } bbc_ctl_t;

  typedef struct packed {
    logic in_is_get;
    logic search_done;
    logic out_free;
  } bbc_sts_t;

endpackage
`default_nettype wire

@@ rtl/bbc_if.sv @@
// Request and response channel interfaces of the buffer cache.
`default_nettype none
interface bbc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  slot;

  modport source (output valid, command, device, block_number, slot, input ready);
  modport sink   (input valid, command, device, block_number, slot, output ready);
endinterface

interface bbc_rsp_if;
  logic                valid;
  logic                ready;
  logic [4:0]          granted_slot;
  bbc_pkg::bbc_status_t status;
  logic                contents_valid;

  modport source (output valid, granted_slot, status, contents_valid, input ready);
  modport sink   (input valid, granted_slot, status, contents_valid, output ready);
endinterface
`default_nettype wire

@@ rtl/bbc_ctrl.sv @@
// Sequencer of the buffer cache: accept, search (gets only), finish.
`default_nettype none
module bbc_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire bbc_pkg::bbc_sts_t sts,
  output bbc_pkg::bbc_ctl_t  ctl
);
  import bbc_pkg::*;

  bbc_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          state_nxt = sts.in_is_get ? S_SEARCH : S_FINISH;
        end
      end
      S_SEARCH: begin
        ctl.step = 1'b1;
        if (sts.search_done) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ rtl/bbc_dp.sv @@
// Datapath of the buffer cache: tags, flags, recency ranks and result register.
`default_nettype none
module bbc_dp #(
  parameter int BUFFER_COUNT = 32
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic [2:0]         in_command,
  input  wire logic [7:0]         in_device,
  input  wire logic [31:0]        in_block_number,
  input  wire logic [4:0]         in_slot,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [4:0]              out_granted_slot,
  output bbc_pkg::bbc_status_t    out_status,
  output logic                    out_contents_valid,
  input  wire bbc_pkg::bbc_ctl_t  ctl,
  output bbc_pkg::bbc_sts_t       sts
);
  import bbc_pkg::*;

  localparam int IW = (BUFFER_COUNT > 1) ? $clog2(BUFFER_COUNT) : 1;
  localparam logic [IW-1:0] LAST = IW'(BUFFER_COUNT - 1);

  logic [7:0]        tag_dev_r [BUFFER_COUNT];
  logic [31:0]       tag_blk_r [BUFFER_COUNT];
  logic [IW-1:0]     rank_r    [BUFFER_COUNT];
  logic [IW-1:0]     rank_nxt  [BUFFER_COUNT];
  logic [BUFFER_COUNT-1:0] busy_r, valid_r, dirty_r;
  logic [BUFFER_COUNT-1:0] busy_nxt, valid_nxt, dirty_nxt;

  logic [2:0]  cmd_r;
  logic [7:0]  dev_r;
  logic [31:0] blk_r;
  logic [4:0]  slot_r;
  logic [IW-1:0] pos_r, hit_pick_r, free_pick_r;
  logic hit_r, free_found_r;

  logic out_valid_r, cv_r;
  logic [4:0] gs_r;
  bbc_status_t st_r;

  logic [BUFFER_COUNT-1:0] hit_vec, free_vec;
  logic [IW-1:0] hit_idx, free_idx, top_pos, s_idx, old_rank;
  logic hit_now, free_now, tag_wr, in_range;
  logic [4:0] gs_nxt;
  bbc_status_t st_nxt;
  logic cv_nxt;

  // Candidate at the current rank position: hits walk up from the most recent
  // end while free buffers walk down from the least recent end.
  always_comb begin
    top_pos  = LAST - pos_r;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      hit_vec[i]  = (tag_dev_r[i] == dev_r) && (tag_blk_r[i] == blk_r) &&
                    (rank_r[i] == pos_r);
      free_vec[i] = !busy_r[i] && !dirty_r[i] && (rank_r[i] == top_pos);
      if (hit_vec[i]) hit_idx = hit_idx | IW'(i);
      if (free_vec[i]) free_idx = free_idx | IW'(i);
    end
    hit_now  = |hit_vec;
    free_now = |free_vec;
  end

  assign sts.in_is_get   = (in_command == CMD_GET);
  assign sts.search_done = hit_now || (pos_r == LAST);
  assign sts.out_free    = !out_valid_r || out_ready;

  always_comb begin
    in_range  = ({4'd0, slot_r} < 9'(BUFFER_COUNT));
    s_idx     = IW'(slot_r);
    old_rank  = rank_r[s_idx];
    busy_nxt  = busy_r;
    valid_nxt = valid_r;
    dirty_nxt = dirty_r;
    for (int i = 0; i < BUFFER_COUNT; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    tag_wr = 1'b0;
    gs_nxt = slot_r;
    st_nxt = RES_DONE;
    cv_nxt = 1'b0;
    if (cmd_r == CMD_GET) begin
      if (hit_r) begin
        gs_nxt = 5'(hit_pick_r);
        cv_nxt = valid_r[hit_pick_r];
        if (busy_r[hit_pick_r]) begin
          st_nxt = RES_BUSY;
        end else begin
          st_nxt = RES_HIT;
          busy_nxt[hit_pick_r] = 1'b1;
        end
      end else if (free_found_r) begin
        gs_nxt = 5'(free_pick_r);
        st_nxt = RES_MISS;
        tag_wr = 1'b1;
        busy_nxt[free_pick_r]  = 1'b1;
        valid_nxt[free_pick_r] = 1'b0;
        dirty_nxt[free_pick_r] = 1'b0;
      end else begin
        gs_nxt = '0;
        st_nxt = RES_NONE;
      end
    end else if (cmd_r > CMD_CLEAR_DIRTY) begin
      st_nxt = RES_DONE;
    end else if (!in_range) begin
      st_nxt = RES_NOTBUSY;
    end else begin
      cv_nxt = valid_r[s_idx];
      priority if (cmd_r == CMD_RELEASE) begin
        if (!busy_r[s_idx]) begin
          st_nxt = RES_NOTBUSY;
        end else begin
          for (int i = 0; i < BUFFER_COUNT; i++) begin
            if (rank_r[i] < old_rank) rank_nxt[i] = rank_r[i] + 1'b1;
          end
          rank_nxt[s_idx] = '0;
          busy_nxt[s_idx] = 1'b0;
        end
      end else if (cmd_r == CMD_MARK_VALID) begin
        valid_nxt[s_idx] = 1'b1;
        cv_nxt = 1'b1;
      end else if (cmd_r == CMD_MARK_DIRTY) begin
        if (!busy_r[s_idx]) begin
          st_nxt = RES_NOTBUSY;
        end else begin
          dirty_nxt[s_idx] = 1'b1;
        end
      end else begin
        dirty_nxt[s_idx] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= '0;
      valid_r      <= '0;
      dirty_r      <= '0;
      hit_r        <= 1'b0;
      free_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        tag_dev_r[i] <= '0;
        tag_blk_r[i] <= '0;
        rank_r[i]    <= IW'(BUFFER_COUNT - 1 - i);
      end
    end else begin
      if (ctl.load) begin
        cmd_r        <= in_command;
        dev_r        <= in_device;
        blk_r        <= in_block_number;
        slot_r       <= in_slot;
        pos_r        <= '0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end
      if (ctl.step) begin
        pos_r <= pos_r + 1'b1;
        if (hit_now) begin
          hit_r      <= 1'b1;
          hit_pick_r <= hit_idx;
        end else if (free_now && !free_found_r) begin
          free_found_r <= 1'b1;
          free_pick_r  <= free_idx;
        end
      end
      if (ctl.finish) begin
        busy_r  <= busy_nxt;
        valid_r <= valid_nxt;
        dirty_r <= dirty_nxt;
        for (int i = 0; i < BUFFER_COUNT; i++) begin
          rank_r[i] <= rank_nxt[i];
        end
        if (tag_wr) begin
          tag_dev_r[free_pick_r] <= dev_r;
          tag_blk_r[free_pick_r] <= blk_r;
        end
        out_valid_r <= 1'b1;
        gs_r        <= gs_nxt;
        st_r        <= st_nxt;
        cv_r        <= cv_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_granted_slot   = gs_r;
  assign out_status         = st_r;
  assign out_contents_valid = cv_r;
endmodule
`default_nettype wire

@@ rtl/block_buffer_cache_lru.sv @@
// Top level of the block buffer cache bookkeeping with recency order.
`default_nettype none
// The block keeps tags, busy, valid and dirty flags and a recency rank for
// BUFFER_COUNT buffers and handles one request beat at a time. Release and the
// mark commands go from acceptance straight to the finish state, which loads
// the result register once the output register is free. A get first walks
// the recency order one rank per cycle: a hit ends the walk at the rank of the
// matching buffer, and a miss walks all BUFFER_COUNT ranks; the finish state
// then loads the result. Each step of the walk compares one rank across all
// tags. A new request is taken once the previous result has been loaded into
// the output register, even if that result beat has not yet been taken
// downstream.
module block_buffer_cache_lru #(
  parameter int BUFFER_COUNT = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  bbc_req_if.sink   in_req,
  bbc_rsp_if.source out_rsp
);
  import bbc_pkg::*;

  bbc_ctl_t ctl;
  bbc_sts_t sts;

  bbc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  bbc_dp #(.BUFFER_COUNT(BUFFER_COUNT)) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_command         (in_req.command),
    .in_device          (in_req.device),
    .in_block_number    (in_req.block_number),
    .in_slot            (in_req.slot),
    .out_ready          (out_rsp.ready),
    .out_valid          (out_rsp.valid),
    .out_granted_slot   (out_rsp.granted_slot),
    .out_status         (out_rsp.status),
    .out_contents_valid (out_rsp.contents_valid),
    .ctl                (ctl),
    .sts                (sts)
  );

  `include "block_buffer_cache_lru_assert.svh"

  // Only one request is in flight: an accepted beat closes the request port.
  `BBC_ASSERT_NXT(a_one_in_flight, clk, rst_n, in_req.valid && in_req.ready, !in_req.ready)
  // A freshly allocated buffer never reports valid contents.
  `BBC_ASSERT_NOW(a_miss_invalid, clk, rst_n,
    out_rsp.valid && (out_rsp.status == RES_MISS), !out_rsp.contents_valid)
  // With no free buffer the result reports slot zero.
  `BBC_ASSERT_NOW(a_none_slot0, clk, rst_n,
    out_rsp.valid && (out_rsp.status == RES_NONE), out_rsp.granted_slot == 5'd0)
endmodule
`default_nettype wire

@@ tb/sv/block_buffer_cache_lru_test.sv @@
// Self-checking testbench for the block buffer cache bookkeeping block.
`timescale 1ns / 100ps
`default_nettype none
// Requests are queued by a stimulus process and presented by a clocked driver.
// A clocked monitor takes response beats and checks them in order against a
// shadow copy of the cache state. That copy is updated when each request beat
// is accepted. The block has one result per request and handles one request at
// a time, so predicting in acceptance order is exact.
module block_buffer_cache_lru_test;
  import bbc_pkg::*;

  localparam int NBUF = 32;
  localparam int QUIET_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  device;
    logic [31:0] block_number;
    logic [4:0]  slot;
  } request_t;

  typedef struct packed {
    logic [4:0]  granted_slot;
    bbc_status_t status;
    logic        contents_valid;
  } response_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bbc_req_if req_bus ();
  bbc_rsp_if rsp_bus ();

  block_buffer_cache_lru #(.BUFFER_COUNT(NBUF)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_req (req_bus.sink),
    .out_rsp(rsp_bus.source)
  );

  always #5 clk = ~clk;

  // Shadow state of the cache. Rank 0 is the most recently used buffer.
  logic [7:0]  shadow_dev [NBUF];
  logic [31:0] shadow_blk [NBUF];
  logic        shadow_busy [NBUF];
  logic        shadow_valid [NBUF];
  logic        shadow_dirty [NBUF];
  int          shadow_rank [NBUF];

  request_t  pending_reqs[$];
  response_t expected_rsps[$];
  int        errors = 0;
  bit        no_idle = 1'b0;
  int        quiet_cycles = 0;

  // Small pool of tags so that gets hit often and buffers fill up.
  logic [7:0]  pool_dev [8];
  logic [31:0] pool_blk [8];

  function automatic response_t cache_apply(request_t r);
    response_t res;
    int pick;
    int old;
    bit found;
    found = 1'b0;
    pick = 0;
    res.granted_slot = r.slot;
    res.status = RES_DONE;
    res.contents_valid = 1'b0;
    if (r.command == CMD_GET) begin
      // Lookup from the most recently used end; the valid flag is ignored.
      for (int i = 0; i < NBUF; i++) begin
        if (shadow_dev[i] == r.device && shadow_blk[i] == r.block_number &&
            (!found || shadow_rank[i] < shadow_rank[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (found) begin
        res.granted_slot = pick[4:0];
        res.contents_valid = shadow_valid[pick];
        if (shadow_busy[pick]) begin
          res.status = RES_BUSY;
        end else begin
          shadow_busy[pick] = 1'b1;
          res.status = RES_HIT;
        end
        return res;
      end
      // Allocation takes the least recently used buffer that is idle and clean.
      for (int i = 0; i < NBUF; i++) begin
        if (!shadow_busy[i] && !shadow_dirty[i] &&
            (!found || shadow_rank[i] > shadow_rank[pick])) begin
          pick = i;
          found = 1'b1;
        end
      end
      if (!found) begin
        res.granted_slot = '0;
        res.status = RES_NONE;
        return res;
      end
      shadow_dev[pick] = r.device;
      shadow_blk[pick] = r.block_number;
      shadow_busy[pick] = 1'b1;
      shadow_valid[pick] = 1'b0;
      shadow_dirty[pick] = 1'b0;
      res.granted_slot = pick[4:0];
      res.status = RES_MISS;
      return res;
    end
    if (r.command > CMD_CLEAR_DIRTY) return res;
    if (int'(r.slot) >= NBUF) begin
      res.status = RES_NOTBUSY;
      return res;
    end
    case (r.command)
      CMD_RELEASE: begin
        if (!shadow_busy[r.slot]) begin
          res.status = RES_NOTBUSY;
          res.contents_valid = shadow_valid[r.slot];
          return res;
        end
        old = shadow_rank[r.slot];
        for (int i = 0; i < NBUF; i++) begin
          if (shadow_rank[i] < old) shadow_rank[i]++;
        end
        shadow_rank[r.slot] = 0;
        shadow_busy[r.slot] = 1'b0;
      end
      CMD_MARK_VALID: shadow_valid[r.slot] = 1'b1;
      CMD_MARK_DIRTY: begin
        if (!shadow_busy[r.slot]) begin
          res.status = RES_NOTBUSY;
          res.contents_valid = shadow_valid[r.slot];
          return res;
        end
        shadow_dirty[r.slot] = 1'b1;
      end
      default: shadow_dirty[r.slot] = 1'b0;
    endcase
    res.contents_valid = shadow_valid[r.slot];
    return res;
  endfunction

  task automatic queue_req(logic [2:0] cmd, logic [7:0] dev, logic [31:0] blk,
                           logic [4:0] slot);
    request_t r;
    r.command = cmd;
    r.device = dev;
    r.block_number = blk;
    r.slot = slot;
    pending_reqs.push_back(r);
  endtask

  // Driver: presents the head of the queue, idling now and then.
  always @(posedge clk) begin
    if (!rst_n) begin
      req_bus.valid <= 1'b0;
    end else begin
      if (req_bus.valid && req_bus.ready) begin
        expected_rsps.push_back(cache_apply(pending_reqs.pop_front()));
      end
      // The valid decision reads the queue after this edge's pop, so a request that
      // was just accepted is never presented a second time.
      if (pending_reqs.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        req_bus.valid <= 1'b1;
        {req_bus.command, req_bus.device, req_bus.block_number, req_bus.slot}
          <= pending_reqs[0];
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Monitor: stalls at random and checks every response beat.
  always @(posedge clk) begin
    response_t want;
    if (!rst_n) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= no_idle || $urandom_range(99) >= 17;
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (expected_rsps.size() == 0) begin
          $error("response beat with nothing expected");
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_bus.granted_slot !== want.granted_slot) begin
            $error("granted_slot: expected %0d, got %0d", want.granted_slot,
                   rsp_bus.granted_slot);
            errors++;
          end
          if (rsp_bus.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
            errors++;
          end
          if (rsp_bus.contents_valid !== want.contents_valid) begin
            $error("contents_valid: expected %0b, got %0b", want.contents_valid,
                   rsp_bus.contents_valid);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: the run ends when no beat moves for too long.
  always @(posedge clk) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    int kind;
    int p;
    req_bus.valid = 1'b0;
    req_bus.command = '0;
    req_bus.device = '0;
    req_bus.block_number = '0;
    req_bus.slot = '0;
    rsp_bus.ready = 1'b0;
    for (int i = 0; i < NBUF; i++) begin
      shadow_dev[i] = '0;
      shadow_blk[i] = '0;
      shadow_busy[i] = 1'b0;
      shadow_valid[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_rank[i] = NBUF - 1 - i;
    end
    for (int i = 0; i < 8; i++) begin
      pool_dev[i] = 8'($urandom);
      pool_blk[i] = $urandom;
    end
    pool_dev[0] = 8'hFF;
    pool_blk[0] = 32'hFFFF_FFFF;

    // Directed part. A zero tag matches every buffer after reset, so the most
    // recent one (the highest slot) is claimed, and a second get sees it busy.
    queue_req(CMD_GET, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_GET, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    queue_req(CMD_MARK_VALID, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_RELEASE, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    queue_req(CMD_CLEAR_DIRTY, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_RELEASE, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_RELEASE, 8'h00, 32'h0, 5'd0);
    queue_req(CMD_MARK_DIRTY, 8'h00, 32'h0, 5'd1);
    queue_req(CMD_RELEASE, 8'h00, 32'h0, 5'd31);
    queue_req(3'd5, 8'h12, 32'h1, 5'd17);
    queue_req(3'd6, 8'h00, 32'h0, 5'd31);
    queue_req(3'd7, 8'hFF, 32'hFFFF_FFFF, 5'd0);
    // Exhaust the cache: 32 distinct gets, then one that finds nothing free.
    for (int i = 0; i < NBUF; i++) queue_req(CMD_GET, 8'hA5, 32'h100 + i, 5'd0);
    queue_req(CMD_GET, 8'h5A, 32'h8000_0000, 5'd0);
    for (int i = 0; i < NBUF; i++) begin
      queue_req(CMD_MARK_DIRTY, 8'h00, 32'h0, i[4:0]);
      queue_req(CMD_RELEASE, 8'h00, 32'h0, i[4:0]);
    end
    queue_req(CMD_GET, 8'h5A, 32'h8000_0001, 5'd0);
    for (int i = 0; i < NBUF; i++) queue_req(CMD_CLEAR_DIRTY, 8'h00, 32'h0, i[4:0]);

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Random part: mostly gets on a small tag pool and valid slot commands,
    // with some fully random noise.
    for (int n = 0; n < 1700; n++) begin
      kind = $urandom_range(99);
      p = $urandom_range(7);
      if (n >= 600 && n < 900) no_idle = 1'b1;
      else no_idle = 1'b0;
      if (kind < 40) begin
        queue_req(CMD_GET, pool_dev[p], pool_blk[p], 5'($urandom));
      end else if (kind < 65) begin
        queue_req(CMD_RELEASE, 8'($urandom), $urandom, 5'($urandom));
      end else if (kind < 90) begin
        queue_req(3'($urandom_range(CMD_CLEAR_DIRTY, CMD_MARK_VALID)), 8'($urandom),
                  $urandom, 5'($urandom));
      end else begin
        queue_req(3'($urandom), 8'($urandom), $urandom, 5'($urandom));
      end
      while (pending_reqs.size() > 8) @(posedge clk);
    end
    no_idle = 1'b0;

    while (pending_reqs.size() > 0 || expected_rsps.size() > 0) @(posedge clk);
    repeat (NBUF + 10) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
